[rtl/poly1305_mac_assert.svh]
// Assertion macros for the Poly1305 controller; clk and rst_n come from the including module.
`ifndef POLY1305_MAC_ASSERT_SVH
`define POLY1305_MAC_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define P1305_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poly1305_mac: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define P1305_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poly1305_mac: assertion failed");

`endif

[rtl/p1305_pkg.sv]
// Shared types and constants of the Poly1305 engine.
`default_nettype none

package p1305_pkg;

    // Radix 2^26 representation of values mod 2^130-5.
    localparam int LIMBS  = 5;
    localparam int LIMB_W = 26;
    localparam int ROW_W  = 3;

    // Pad bit 2^128 sits at bit 24 of the top limb.
    localparam int HIBIT_POS = 24;

    // Clamping masks applied to the limbs of r.
    localparam logic [LIMB_W-1:0] R_CLAMP [LIMBS] = '{
        26'h3ffffff, 26'h3ffff03, 26'h3ffc0ff, 26'h3f03fff, 26'h00fffff
    };

    // Configuration register indexes.
    localparam logic [1:0] REG_R_LOW  = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW  = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    typedef logic [ROW_W-1:0] row_t;

    // Commands from the controller to the datapath; at most one is active per cycle.
    typedef struct packed {
        logic load;       // add the padded block into the accumulator copy
        logic row_en;     // compute one product row
        row_t row;        // which row
        logic fix;        // fold the top carry back into limb 0
        logic fin_carry;  // final carry propagation
        logic fin_pack;   // conditional subtraction of p and packing
        logic fin_out;    // add s, write the tag, clear the accumulator
    } cmd_t;

    typedef struct packed {
        logic has_data;   // the presented block carries at least one byte
    } status_t;

endpackage

`default_nettype wire

[rtl/p1305_dp.sv]
// Datapath of the Poly1305 engine: key registers, accumulator limbs, row multiplier and final reduction.
`default_nettype none

module p1305_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wen,
    input  logic [1:0]              cfg_index,
    input  logic [63:0]             cfg_data,
    input  logic [63:0]             block_low,
    input  logic [63:0]             block_high,
    input  logic [4:0]              byte_count,
    input  p1305_pkg::cmd_t         cmd,
    output p1305_pkg::status_t      status,
    output logic [63:0]             tag_low,
    output logic [63:0]             tag_high
);

    logic [63:0]  r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic [26:0]  h_reg  [p1305_pkg::LIMBS];
    logic [26:0]  h_next [p1305_pkg::LIMBS];
    logic [27:0]  a_reg  [p1305_pkg::LIMBS];
    logic [31:0]  c_reg;
    logic [63:0]  f_low_reg, f_high_reg;
    logic [63:0]  tag_low_reg, tag_high_reg;

    logic [4:0]   cnt_eff;
    logic         full;
    logic [127:0] blk;
    logic [127:0] msg;
    logic [127:0] rkey;
    logic [25:0]  m    [p1305_pkg::LIMBS];
    logic [28:0]  rc   [p1305_pkg::LIMBS];
    logic [28:0]  s5   [p1305_pkg::LIMBS];
    logic [28:0]  rv   [p1305_pkg::LIMBS];
    logic [56:0]  prod [p1305_pkg::LIMBS];
    logic [59:0]  dsum;
    logic [31:0]  fix0;
    logic [31:0]  fc   [p1305_pkg::LIMBS];
    logic [31:0]  fc_t, fc_c;
    logic [31:0]  g    [p1305_pkg::LIMBS];
    logic [31:0]  sel  [p1305_pkg::LIMBS];
    logic [31:0]  g_t, g_c;
    logic         use_g;
    logic [63:0]  f_low, f_high;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                p1305_pkg::REG_R_LOW:  r_low_reg  <= cfg_data;
                p1305_pkg::REG_R_HIGH: r_high_reg <= cfg_data;
                p1305_pkg::REG_S_LOW:  s_low_reg  <= cfg_data;
                p1305_pkg::REG_S_HIGH: s_high_reg <= cfg_data;
                default:               r_low_reg  <= r_low_reg;
            endcase
        end
    end

    // Block padding: bytes past the count are dropped and a 0x01 byte marks the end.
    assign cnt_eff = byte_count[4] ? 5'd16 : byte_count;
    assign full    = cnt_eff[4];
    assign blk     = {block_high, block_low};
    assign status.has_data = (cnt_eff != 5'd0);

    always_comb
    begin
        for (int b = 0; b < 16; b++)
        begin
            if (full || (5'(b) < cnt_eff))
                msg[b*8 +: 8] = blk[b*8 +: 8];
            else if (5'(b) == cnt_eff)
                msg[b*8 +: 8] = 8'h01;
            else
                msg[b*8 +: 8] = 8'h00;
        end
    end

    // Limb split of the message and of the clamped r, plus 5*r for the wrapped terms.
    assign rkey = {r_high_reg, r_low_reg};

    always_comb
    begin
        for (int i = 0; i < p1305_pkg::LIMBS - 1; i++)
        begin
            m[i]  = msg[i*p1305_pkg::LIMB_W +: p1305_pkg::LIMB_W];
            rc[i] = 29'(rkey[i*p1305_pkg::LIMB_W +: p1305_pkg::LIMB_W]
                        & p1305_pkg::R_CLAMP[i]);
        end
        m[p1305_pkg::LIMBS-1]  = 26'(msg[127:104]);
        rc[p1305_pkg::LIMBS-1] = 29'(26'(rkey[127:104])
                                    & p1305_pkg::R_CLAMP[p1305_pkg::LIMBS-1]);
        for (int i = 0; i < p1305_pkg::LIMBS; i++)
            s5[i] = 29'(rc[i] * 29'd5);
    end

    // One row of the schoolbook product: d[row] = sum_j a[j] * r[row-j], wrapped terms use 5*r.
    always_comb
    begin
        for (int j = 0; j < p1305_pkg::LIMBS; j++)
        begin
            if (3'(j) <= cmd.row)
                rv[j] = rc[cmd.row - 3'(j)];
            else
                rv[j] = s5[cmd.row + 3'(p1305_pkg::LIMBS) - 3'(j)];
            prod[j] = a_reg[j] * rv[j];
        end
        dsum = 60'(c_reg);
        for (int j = 0; j < p1305_pkg::LIMBS; j++)
            dsum = dsum + 60'(prod[j]);
    end

    // Fold of the carry out of the top limb: 2^130 = 5 mod p.
    assign fix0 = 32'(h_reg[0]) + 32'(c_reg * 32'd5);

    // Final carry propagation over limbs 1..4, then back into limb 0.
    always_comb
    begin
        fc_c = '0;
        for (int i = 1; i < p1305_pkg::LIMBS; i++)
        begin
            fc_t  = 32'(h_reg[i]) + fc_c;
            fc_c  = {6'd0, fc_t[31:26]};
            fc[i] = {6'd0, fc_t[25:0]};
        end
        fc_t  = 32'(h_reg[0]) + 32'(fc_c * 32'd5);
        fc_c  = {6'd0, fc_t[31:26]};
        fc[0] = {6'd0, fc_t[25:0]};
        fc[1] = fc[1] + fc_c;
    end

    // h + 5 - 2^130; when that does not go negative, h was at least p.
    always_comb
    begin
        g_c = 32'd5;
        for (int i = 0; i < p1305_pkg::LIMBS - 1; i++)
        begin
            g_t  = 32'(h_reg[i]) + g_c;
            g_c  = {6'd0, g_t[31:26]};
            g[i] = {6'd0, g_t[25:0]};
        end
        g[p1305_pkg::LIMBS-1] = 32'(h_reg[p1305_pkg::LIMBS-1]) + g_c - 32'h0400_0000;
        use_g = ~g[p1305_pkg::LIMBS-1][31];
        for (int i = 0; i < p1305_pkg::LIMBS; i++)
            sel[i] = use_g ? g[i] : 32'(h_reg[i]);
        f_low  = 64'(sel[0]) | (64'(sel[1]) << 26) | (64'(sel[2]) << 52);
        f_high = (64'(sel[2]) >> 12) | (64'(sel[3]) << 14) | (64'(sel[4]) << 40);
    end

    // Accumulator next value.
    always_comb
    begin
        h_next = h_reg;
        if (cmd.row_en)
            h_next[cmd.row] = 27'(dsum[25:0]);
        else if (cmd.fix)
        begin
            h_next[0] = 27'(fix0[25:0]);
            h_next[1] = h_reg[1] + 27'(fix0[31:26]);
        end
        else if (cmd.fin_carry)
        begin
            for (int i = 0; i < p1305_pkg::LIMBS; i++)
                h_next[i] = 27'(fc[i]);
        end
        else if (cmd.fin_out)
        begin
            for (int i = 0; i < p1305_pkg::LIMBS; i++)
                h_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < p1305_pkg::LIMBS; i++)
                h_reg[i] <= '0;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < p1305_pkg::LIMBS - 1; i++)
                a_reg[i] <= 28'(h_reg[i]) + 28'(m[i]);
            a_reg[p1305_pkg::LIMBS-1] <= 28'(h_reg[p1305_pkg::LIMBS-1])
                + 28'(m[p1305_pkg::LIMBS-1])
                + (full ? (28'd1 << p1305_pkg::HIBIT_POS) : 28'd0);
            c_reg <= '0;
        end
        else if (cmd.row_en)
        begin
            c_reg <= dsum[57:26];
        end
        if (cmd.fin_pack)
        begin
            f_low_reg  <= f_low;
            f_high_reg <= f_high;
        end
        if (cmd.fin_out)
        begin
            {tag_high_reg, tag_low_reg} <= {f_high_reg, f_low_reg} + {s_high_reg, s_low_reg};
        end
    end

    assign tag_low  = tag_low_reg;
    assign tag_high = tag_high_reg;

endmodule

`default_nettype wire

[rtl/p1305_ctrl.sv]
// Controller of the Poly1305 engine: sequences limb rows, reduction and the tag output register.
`default_nettype none
`include "poly1305_mac_assert.svh"

module p1305_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                block_valid,
    output logic                block_ready,
    input  logic                last,
    output logic                tag_valid,
    input  logic                tag_ready,
    input  p1305_pkg::status_t  status,
    output p1305_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROW  = 3'd1;
    localparam logic [2:0] ST_FIX  = 3'd2;
    localparam logic [2:0] ST_FIN1 = 3'd3;
    localparam logic [2:0] ST_FIN2 = 3'd4;
    localparam logic [2:0] ST_FIN3 = 3'd5;

    localparam p1305_pkg::row_t ROW_LAST = p1305_pkg::ROW_W'(p1305_pkg::LIMBS - 1);

    logic [2:0]       state_reg, state_next;
    p1305_pkg::row_t  row_reg, row_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             slot_free;

    assign block_ready = (state_reg == ST_IDLE);
    assign accept      = block_valid && block_ready;
    assign slot_free   = !out_valid_reg || tag_ready;
    assign tag_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = last;
                    if (status.has_data)
                    begin
                        cmd.load   = 1'b1;
                        row_next   = '0;
                        state_next = ST_ROW;
                    end
                    else if (last)
                        state_next = ST_FIN1;
                end
            end
            ST_ROW:
            begin
                cmd.row_en = 1'b1;
                if (row_reg == ROW_LAST)
                    state_next = ST_FIX;
                else
                    row_next = row_reg + 1'b1;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                cmd.fin_carry = 1'b1;
                state_next    = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.fin_pack = 1'b1;
                state_next   = ST_FIN3;
            end
            ST_FIN3:
            begin
                if (slot_free)
                begin
                    cmd.fin_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.fin_out)
            out_valid_next = 1'b1;
        else if (tag_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `P1305_ASSERT_NEXT(a_load_starts_rows, accept && status.has_data, state_reg == ST_ROW && row_reg == '0)
    `P1305_ASSERT_SAME(a_row_in_range, state_reg == ST_ROW, row_reg <= ROW_LAST)
    `P1305_ASSERT_NEXT(a_last_row_folds, state_reg == ST_ROW && row_reg == ROW_LAST, state_reg == ST_FIX)
    `P1305_ASSERT_NEXT(a_tag_waits_for_slot, state_reg == ST_FIN3 && out_valid_reg && !tag_ready, state_reg == ST_FIN3 && out_valid_reg)

endmodule

`default_nettype wire

[rtl/poly1305_mac.sv]
// poly1305_mac: top level of the Poly1305 tag engine, a sequencing controller over a limb datapath.
// A block with data is absorbed after its transaction in five product rows and one carry fold.
// A new block is taken only after the five-row multiply on the accumulator has finished.
// A final block then runs the carry, pack and tag-load steps (an empty final block only these).
// rst_n low (asynchronous) clears the key registers, the accumulator and all control state.
`default_nettype none

module poly1305_mac (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: r_low, r_high, s_low, s_high at indexes 0..3.
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Message blocks.
    input  logic        block_valid,
    output logic        block_ready,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic [4:0]  byte_count,
    input  logic        last,
    // Tags.
    output logic        tag_valid,
    input  logic        tag_ready,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high
);

    // The controller decides what happens each cycle; the datapath only follows commands.
    // A block transaction is taken only while the controller is idle. Blocks with data run
    // one product row per cycle (each row is five limb products summed with the running
    // carry), then the carry out of the top limb is folded back as 5 times its value.
    p1305_pkg::cmd_t    cmd;
    p1305_pkg::status_t status;

    p1305_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_valid (block_valid),
        .block_ready (block_ready),
        .last        (last),
        .tag_valid   (tag_valid),
        .tag_ready   (tag_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // The datapath pads short blocks, clamps r on the fly from the key registers, keeps the
    // accumulator in five 26-bit limbs and, on the final block, fully reduces mod 2^130-5,
    // adds s mod 2^128 and loads the tag register. The tag register is a separate output
    // stage, so the next message can be absorbed while a tag is still waiting; the final
    // step of a later message waits only if that register is still occupied.
    p1305_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .block_low  (block_low),
        .block_high (block_high),
        .byte_count (byte_count),
        .cmd        (cmd),
        .status     (status),
        .tag_low    (tag_low),
        .tag_high   (tag_high)
    );

endmodule

`default_nettype wire

[tb/tb_poly1305_mac.sv]
`timescale 1ns / 1ps
// Self-checking testbench for poly1305_mac: streams message blocks, predicts each tag, compares.

module tb_poly1305_mac;

    // The prime 2^130 - 5 and the standard clamp applied to r.
    localparam logic [259:0] PRIME      = (260'd1 << 130) - 260'd5;
    localparam logic [259:0] LOW130     = (260'd1 << 130) - 260'd1;
    localparam logic [127:0] CLAMP_R    = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
    // Cycles allowed for the engine to finish an absorb or a tag after the last transaction.
    localparam int           IDLE_SETTLE = 24;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } tag_t;

    // All inputs of the block start at known values.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wen     = 1'b0;
    logic [1:0]  cfg_index   = p1305_pkg::REG_R_LOW;
    logic [63:0] cfg_data    = '0;
    logic        block_valid = 1'b0;
    logic        block_ready;
    logic [63:0] block_low   = '0;
    logic [63:0] block_high  = '0;
    logic [4:0]  byte_count  = '0;
    logic        last        = 1'b0;
    logic        tag_valid;
    logic        tag_ready   = 1'b0;
    logic [63:0] tag_low;
    logic [63:0] tag_high;

    // Private copy of the key registers and of the accumulator, fully reduced mod p.
    logic [63:0]  key_r_low  = '0;
    logic [63:0]  key_r_high = '0;
    logic [63:0]  key_s_low  = '0;
    logic [63:0]  key_s_high = '0;
    logic [129:0] mac_acc    = '0;

    // Tags that the engine still owes us, oldest first.
    tag_t tag_expect[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int tags_expected = 0;
    int tags_checked  = 0;
    int key_loads     = 0;

    // Idling controls. rx_hold is set on a rising edge and counted down by the receiver.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold    = 0;

    poly1305_mac i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .block_valid (block_valid),
        .block_ready (block_ready),
        .block_low   (block_low),
        .block_high  (block_high),
        .byte_count  (byte_count),
        .last        (last),
        .tag_valid   (tag_valid),
        .tag_ready   (tag_ready),
        .tag_low     (tag_low),
        .tag_high    (tag_high)
    );

    // Free-running 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reduce a product below 2^260 into the range [0, p) by folding 2^130 = 5 (mod p).
    function automatic logic [129:0] reduce_mod_p(input logic [259:0] x);
        logic [259:0] v;
        v = x;
        while ((v >> 130) != 0)
            v = (v & LOW130) + (v >> 130) * 260'd5;
        if (v >= PRIME)
            v = v - PRIME;
        return v[129:0];
    endfunction

    // Advance the predicted accumulator by one accepted transaction, and queue a tag on last.
    task automatic predict_block(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] cnt, input logic lst);
        logic [4:0]   n;
        logic [127:0] data;
        logic [129:0] msg;
        logic [259:0] sum;
        logic [259:0] rk;
        tag_t         t;
        // Counts above 16 behave as a full block.
        n = (cnt > 5'd16) ? 5'd16 : cnt;
        data = {hi, lo};
        // A full block carries the pad bit at 2^128; a short one gets a 1 byte at its length
        // and loses every byte above it.
        if (n == 5'd16)
            msg = {2'b01, data};
        else
            msg = {2'b00, data & ((128'd1 << (8 * n)) - 128'd1)} | (130'd1 << (8 * n));
        if (n != 5'd0)
        begin
            rk = {132'd0, {key_r_high, key_r_low} & CLAMP_R};
            sum = {130'd0, mac_acc} + {130'd0, msg};
            mac_acc = reduce_mod_p(sum * rk);
        end
        if (lst)
        begin
            {t.hi, t.lo} = mac_acc[127:0] + {key_s_high, key_s_low};
            tag_expect.push_back(t);
            tags_expected++;
            mac_acc = '0;
        end
    endtask

    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    // Write one key register. Called on a falling edge, returns on a later one with nothing
    // driven in that step.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            p1305_pkg::REG_R_LOW:  key_r_low  = val;
            p1305_pkg::REG_R_HIGH: key_r_high = val;
            p1305_pkg::REG_S_LOW:  key_s_low  = val;
            default:               key_s_high = val;
        endcase
        @(negedge clk);
    endtask

    task automatic write_key(input logic [63:0] rl, input logic [63:0] rh,
                             input logic [63:0] sl, input logic [63:0] sh);
        write_reg(p1305_pkg::REG_R_LOW, rl);
        write_reg(p1305_pkg::REG_R_HIGH, rh);
        write_reg(p1305_pkg::REG_S_LOW, sl);
        write_reg(p1305_pkg::REG_S_HIGH, sh);
        key_loads++;
    endtask

    // Each key word is zero or all ones now and then, random otherwise.
    function automatic logic [63:0] rand_key_word();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return rand_word64();
    endfunction

    // Offer one block transaction and hold it until the engine takes it. The prediction is
    // updated on the falling edge after acceptance, so it never races the tag checker.
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt, input logic lst);
        while (tx_idle_on && $urandom_range(0, 99) < 10)
        begin
            block_valid <= 1'b0;
            @(negedge clk);
        end
        block_valid <= 1'b1;
        block_low   <= lo;
        block_high  <= hi;
        byte_count  <= cnt;
        last        <= lst;
        @(posedge clk);
        while (!block_ready)
            @(posedge clk);
        @(negedge clk);
        predict_block(lo, hi, cnt, lst);
        items_sent++;
    endtask

    // Drop valid, wait for every owed tag, then give the engine time to finish any absorb that
    // produces no tag. Only after this may key registers change.
    task automatic wait_idle();
        block_valid <= 1'b0;
        while (tag_expect.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE)
            @(negedge clk);
    endtask

    // Right after reset the key is all zero, so any message must give a zero tag.
    task automatic test_reset_key();
        send_block(rand_word64(), rand_word64(), 5'd16, 1'b1);
        wait_idle();
    endtask

    // An empty message yields s itself; an empty block inside a message changes nothing.
    task automatic test_empty_messages();
        write_key(rand_word64(), rand_word64(), rand_word64(), rand_word64());
        send_block(rand_word64(), rand_word64(), 5'd0, 1'b1);
        send_block(rand_word64(), rand_word64(), 5'd0, 1'b0);
        send_block(rand_word64(), rand_word64(), 5'd0, 1'b1);
        wait_idle();
    endtask

    // The published 34-byte example, two full blocks and a two-byte tail.
    task automatic test_rfc_vector();
        write_key(64'h336d5557_78bed685, 64'ha806d542_fe52447f,
                  64'hfdb20dfb_8a800301, 64'h1bf54941_aff6bf4a);
        send_block(64'h72676f74_70797243, 64'h6f462063_69687061, 5'd16, 1'b0);
        send_block(64'h65736552_206d7572, 64'h6f724720_68637261, 5'd16, 1'b0);
        send_block(64'h00000000_00007075, 64'h0, 5'd2, 1'b1);
        wait_idle();
    endtask

    // Extreme keys and data, every interesting length, oversize counts and short blocks that
    // do not end the message. All-ones data shows that bytes past the count are dropped.
    task automatic test_block_lengths();
        write_key('1, '1, '1, '1);
        send_block('1, '1, 5'd16, 1'b0);
        send_block('0, '0, 5'd16, 1'b0);
        send_block('1, '1, 5'd1, 1'b0);
        send_block('1, '1, 5'd7, 1'b0);
        send_block('1, '1, 5'd8, 1'b0);
        send_block('1, '1, 5'd9, 1'b0);
        send_block('1, '1, 5'd17, 1'b0);
        send_block('1, '1, 5'd31, 1'b0);
        send_block('1, '1, 5'd15, 1'b1);
        wait_idle();
        write_key('0, '0, '0, '0);
        send_block('1, '1, 5'd16, 1'b1);
        wait_idle();
    endtask

    // The accumulator survives a key change between blocks of one message.
    task automatic test_key_change_mid_message();
        write_key(rand_word64(), rand_word64(), rand_word64(), rand_word64());
        send_block(rand_word64(), rand_word64(), 5'd16, 1'b0);
        send_block(rand_word64(), rand_word64(), 5'd16, 1'b0);
        wait_idle();
        write_reg(p1305_pkg::REG_R_LOW, rand_word64());
        write_reg(p1305_pkg::REG_R_HIGH, rand_word64());
        write_reg(p1305_pkg::REG_S_LOW, rand_word64());
        send_block(rand_word64(), rand_word64(), 5'd16, 1'b1);
        wait_idle();
    endtask

    // The receiver refuses tags for a long stretch while one-block messages keep coming, so
    // the engine fills up and must stall its input.
    task automatic test_backpressure();
        int i;
        write_key(rand_word64(), rand_word64(), rand_word64(), rand_word64());
        @(posedge clk);
        rx_hold = 400;
        @(negedge clk);
        for (i = 0; i < 30; i++)
            send_block(rand_word64(), rand_word64(), 5'($urandom_range(0, 16)), 1'b1);
        wait_idle();
    endtask

    // Mostly well-formed messages (full blocks then a tail of any length), some noise: oversize
    // counts, short or empty blocks mid-message. Fresh keys every few dozen messages, and one
    // stretch of messages with neither side idling.
    task automatic test_random_messages(input int n_items);
        int start;
        int msg;
        int nblk;
        int i;
        start = items_sent;
        msg = 0;
        while (items_sent - start < n_items)
        begin
            if (msg % 25 == 0)
            begin
                wait_idle();
                write_key(rand_key_word(), rand_key_word(), rand_key_word(), rand_key_word());
            end
            tx_idle_on = !(msg >= 200 && msg < 280);
            rx_idle_on = tx_idle_on;
            if ($urandom_range(0, 99) < 85)
            begin
                nblk = $urandom_range(0, 5);
                for (i = 0; i < nblk; i++)
                    send_block(rand_word64(), rand_word64(), 5'd16, 1'b0);
                send_block(rand_word64(), rand_word64(), 5'($urandom_range(0, 16)), 1'b1);
            end
            else
            begin
                send_block(rand_word64(), rand_word64(), 5'($urandom_range(0, 31)),
                           1'($urandom_range(0, 1)));
            end
            msg++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_idle();
    endtask

    // Tag receiver: honors a requested hold-off first, otherwise idles about one cycle in ten
    // unless idling is switched off.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            tag_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (!rx_idle_on)
            tag_ready <= 1'b1;
        else
            tag_ready <= ($urandom_range(0, 99) >= 10);
    end

    // Every tag transaction is matched against the oldest owed tag, field by field.
    always @(posedge clk)
    begin : check_tags
        tag_t want;
        if (rst_n && tag_valid && tag_ready)
        begin
            if (tag_expect.size() == 0)
            begin
                $error("unexpected tag transaction: tag_high %h tag_low %h", tag_high, tag_low);
                fail_count++;
            end
            else
            begin
                want = tag_expect.pop_front();
                tags_checked++;
                if (tag_low !== want.lo)
                begin
                    $error("tag_low: expected %h, actual %h", want.lo, tag_low);
                    fail_count++;
                end
                if (tag_high !== want.hi)
                begin
                    $error("tag_high: expected %h, actual %h", want.hi, tag_high);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset once, then each test in turn. Every test leaves the engine idle,
    // so the last one also serves as the final drain.
    initial
    begin
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_key();
        test_empty_messages();
        test_rfc_vector();
        test_block_lengths();
        test_key_change_mid_message();
        test_backpressure();
        test_random_messages(1500);
        if (tag_expect.size() != 0)
        begin
            $error("%0d tags never arrived", tag_expect.size());
            fail_count++;
        end
        $display("Sent %0d block transactions under %0d key settings, including a long tag stall.",
                 items_sent, key_loads);
        $display("Compared %0d of %0d predicted tags; %0d mismatches.",
                 tags_checked, tags_expected, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/p1305_pkg.sv
rtl/p1305_dp.sv
rtl/p1305_ctrl.sv
rtl/poly1305_mac.sv
tb/tb_poly1305_mac.sv
